FILE: rtl/core/bda_pkg.sv
// bda_pkg: shared types and constants for the button debounce / auto repeat unit.
// Used by bda_core and button_debounce_autorepeat_unit. No dependencies.
`timescale 1ns / 1ps

package bda_pkg;

	localparam int unsigned BOUNCE_W = 5;
	localparam int unsigned DELAY_W  = 8;
	localparam int unsigned PCNT_W   = 6;
	localparam int unsigned BCNT_W   = 8;

	localparam logic [BOUNCE_W-1:0] BOUNCE_RST = 5'd5;
	localparam logic [DELAY_W-1:0]  DELAY_RST  = 8'd100;

	// pedal counter saturation and fire offset
	localparam logic [PCNT_W-1:0] PEDAL_WRAP  = 6'd40;
	localparam logic [PCNT_W-1:0] PEDAL_CAP   = 6'd39;
	localparam logic [PCNT_W-1:0] PEDAL_EXTRA = 6'd15;

	// configuration register indexes
	localparam logic CFG_BOUNCE = 1'b0;
	localparam logic CFG_DELAY  = 1'b1;

	typedef struct packed {
		logic pedal_level;
		logic up_level;
		logic down_level;
		logic select_level;
		logic machine_running;
		logic custom_entry_mode;
	} bda_in_t;

	typedef struct packed {
		logic pedal_fire;
		logic up_fire;
		logic down_fire;
		logic select_fire;
	} bda_out_t;

endpackage

FILE: rtl/core/bda_core.sv
// bda_core: debounce counters, repeat flags and per-tick fire decode.
// Depends on bda_pkg. One sample tick is processed when step is high.
`timescale 1ns / 1ps

module bda_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  bda_pkg::bda_in_t              tick,
	input  logic [bda_pkg::BOUNCE_W-1:0]  bounce,
	input  logic [bda_pkg::DELAY_W-1:0]   delay,
	output bda_pkg::bda_out_t             fire
);
	import bda_pkg::*;

	typedef struct packed {
		logic              fire;
		logic [BCNT_W-1:0] cnt;
		logic              waiting;
		logic              active;
	} arrow_t;

	function automatic arrow_t arrow_step(
		input logic [BCNT_W-1:0]   cnt,
		input logic                custom,
		input logic                waiting,
		input logic                active,
		input logic [BOUNCE_W-1:0] bnc,
		input logic [DELAY_W-1:0]  dly
	);
		arrow_t r;
		r.fire    = 1'b0;
		r.cnt     = cnt;
		r.waiting = waiting;
		r.active  = active;
		if (!custom) begin
			r.fire = (cnt == BCNT_W'(bnc));
		end else if (!waiting && !active) begin
			r.waiting = 1'b1;
			r.fire    = 1'b1;
		end else begin
			if (cnt == dly) begin
				r.active  = 1'b1;
				r.waiting = 1'b0;
				r.cnt     = BCNT_W'(bnc);
			end
			if (r.active) begin
				r.cnt  = BCNT_W'(bnc) + BCNT_W'(1);
				r.fire = 1'b1;
			end
		end
		return r;
	endfunction

	logic [PCNT_W-1:0] pcnt_q;
	logic [BCNT_W-1:0] ucnt_q, dcnt_q, scnt_q;
	logic [3:0]        prev_q;
	logic              waiting_q, active_q;

	logic              cur_p, cur_u, cur_d, cur_s;
	logic [3:0]        cur, chg;
	logic [PCNT_W-1:0] pinc, pcnt_n;
	logic [BCNT_W-1:0] ucnt_a, dcnt_a, scnt_a;
	logic [BCNT_W-1:0] ucnt_n, dcnt_n, scnt_n;
	logic              active_a, waiting_n, active_n;
	arrow_t            up_r, dn_r;
	bda_out_t          fire_n;

	always_comb begin
		cur_p = tick.pedal_level;
		cur_u = !cur_p && !tick.up_level;
		cur_d = !cur_p && tick.up_level && !tick.down_level;
		cur_s = !cur_p && tick.up_level && tick.down_level && !tick.select_level;
		cur   = {cur_s, cur_d, cur_u, cur_p};
		chg   = cur ^ prev_q;

		pinc = pcnt_q + PCNT_W'(1);
		if (pinc == PEDAL_WRAP) begin
			pinc = PEDAL_CAP;
		end
		pcnt_n = chg[0] ? '0 : (cur_p ? pinc : pcnt_q);
		ucnt_a = chg[1] ? '0 : (cur_u ? ucnt_q + BCNT_W'(1) : ucnt_q);
		dcnt_a = chg[2] ? '0 : (cur_d ? dcnt_q + BCNT_W'(1) : dcnt_q);
		scnt_a = chg[3] ? '0 : (cur_s ? scnt_q + BCNT_W'(1) : scnt_q);
		active_a = active_q && !chg[1] && !chg[2];

		up_r = arrow_step(ucnt_a, tick.custom_entry_mode, waiting_q, active_a, bounce, delay);
		dn_r = arrow_step(dcnt_a, tick.custom_entry_mode, waiting_q, active_a, bounce, delay);

		fire_n    = '0;
		ucnt_n    = ucnt_a;
		dcnt_n    = dcnt_a;
		scnt_n    = scnt_a;
		waiting_n = waiting_q;
		active_n  = active_a;
		fire_n.pedal_fire = (pcnt_n == PCNT_W'(bounce) + PEDAL_EXTRA);
		if (!tick.machine_running) begin
			if (ucnt_a >= BCNT_W'(bounce)) begin
				fire_n.up_fire = up_r.fire;
				ucnt_n         = up_r.cnt;
				waiting_n      = up_r.waiting;
				active_n       = up_r.active;
			end else if (dcnt_a >= BCNT_W'(bounce)) begin
				fire_n.down_fire = dn_r.fire;
				dcnt_n           = dn_r.cnt;
				waiting_n        = dn_r.waiting;
				active_n         = dn_r.active;
			end else begin
				fire_n.select_fire = (scnt_a == BCNT_W'(bounce));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q    <= '0;
			ucnt_q    <= '0;
			dcnt_q    <= '0;
			scnt_q    <= '0;
			prev_q    <= '0;
			waiting_q <= 1'b0;
			active_q  <= 1'b0;
		end else if (step) begin
			pcnt_q    <= pcnt_n;
			ucnt_q    <= ucnt_n;
			dcnt_q    <= dcnt_n;
			scnt_q    <= scnt_n;
			prev_q    <= cur;
			waiting_q <= waiting_n;
			active_q  <= active_n;
		end
	end

	assign fire = fire_n;

endmodule

FILE: rtl/core/button_debounce_autorepeat_unit.sv
// button_debounce_autorepeat_unit: top level, input register, result register, config.
// Depends on bda_pkg and bda_core.
//
//   channel | direction | handshake           | beat
//   in      | in        | in_valid/in_ready   | bda_in_t, one sample tick
//   out     | out       | out_valid/out_ready | bda_out_t, fire pulses for that tick
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready stays high; a tick waits in the input register
// and then sits in the result register, whose valid flag drives out_valid.
// The counter update between the two registers sets the cycle time.
// arst_n clears counters, flags and both valids; config resets to 5 and 100.
// A stalled result holds one more tick in the input register before in_ready drops.
`timescale 1ns / 1ps

module button_debounce_autorepeat_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bda_pkg::bda_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bda_pkg::bda_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [bda_pkg::DELAY_W-1:0]   cfg_data
);
	import bda_pkg::*;

	bda_in_t              in_s1;
	logic                 vld_s1;
	bda_out_t             res_q;
	logic                 res_vld_q;
	logic [BOUNCE_W-1:0]  bounce_q;
	logic [DELAY_W-1:0]   delay_q;
	logic                 adv;
	bda_out_t             fire;

	assign adv       = vld_s1 && (!res_vld_q || out_ready);
	assign in_ready  = !vld_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
			bounce_q  <= BOUNCE_RST;
			delay_q   <= DELAY_RST;
		end else begin
			if (in_valid && in_ready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				res_vld_q <= 1'b1;
			end else if (out_ready) begin
				res_vld_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_BOUNCE: bounce_q <= cfg_data[BOUNCE_W-1:0];
					CFG_DELAY:  delay_q  <= cfg_data;
					default:    delay_q  <= delay_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
		if (adv) begin
			res_q <= fire;
		end
	end

	bda_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.tick   (in_s1),
		.bounce (bounce_q),
		.delay  (delay_q),
		.fire   (fire)
	);

	assign out_valid = res_vld_q;
	assign out_data  = res_q;

endmodule
